// ===== sv/plane_quantized_dedup_set_assert.svh =====
// Assertion macros shared by the plane dedup set.
`ifndef PLANE_QUANTIZED_DEDUP_SET_ASSERT_SVH
`define PLANE_QUANTIZED_DEDUP_SET_ASSERT_SVH

// Implication checked on every rising clock edge outside reset.
`define PQD_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define PQD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== sv/pqds_pkg.sv =====
// ----------------------------------------------------------------------------
// pqds_pkg
// Shared types and constants of the plane dedup set.
// ----------------------------------------------------------------------------
package pqds_pkg;
  localparam int TABLE_DEPTH_DEF   = 256;
  localparam int ANGLE_W           = 15;
  localparam int LENGTH_W          = 31;
  localparam logic [14:0] ANGLE_RST  = 15'd1638;
  localparam logic [30:0] LENGTH_RST = 31'd65536;
  localparam logic CFG_ANGLE  = 1'b0;
  localparam logic CFG_LENGTH = 1'b1;

  // Datapath operations issued by the controller.
  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,
    OP_DOT,
    OP_DIV,
    OP_SCAN,
    OP_STORE
  } pqds_op_t;

  typedef struct packed {
    pqds_op_t   op;
    logic [1:0] div_sel;   // 0..2 normal components, 3 offset
  } pqds_cmd_t;

  typedef struct packed {
    logic dot_done;
    logic div_done;
    logic scan_done;
  } pqds_sts_t;
endpackage

// ===== sv/pqds_if.sv =====
// ----------------------------------------------------------------------------
// pqds_in_if / pqds_out_if / pqds_cfg_if
// Valid/ready channels of the plane dedup set.
// ----------------------------------------------------------------------------
interface pqds_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] normal_x;
  logic signed [15:0] normal_y;
  logic signed [15:0] normal_z;
  logic signed [31:0] point_x;
  logic signed [31:0] point_y;
  logic signed [31:0] point_z;
  modport source (output valid, normal_x, normal_y, normal_z, point_x, point_y, point_z,
                  input ready);
  modport sink (input valid, normal_x, normal_y, normal_z, point_x, point_y, point_z,
                output ready);
endinterface

interface pqds_out_if;
  logic               valid;
  logic               ready;
  logic               is_new;
  logic               dropped;
  logic signed [15:0] key_nx;
  logic signed [15:0] key_ny;
  logic signed [15:0] key_nz;
  logic signed [31:0] key_offset;
  modport source (output valid, is_new, dropped, key_nx, key_ny, key_nz, key_offset,
                  input ready);
  modport sink (input valid, is_new, dropped, key_nx, key_ny, key_nz, key_offset,
                output ready);
endinterface

interface pqds_cfg_if;
  logic        valid;
  logic        ready;
  logic [0:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== sv/plane_quantized_dedup_set.sv =====
// ----------------------------------------------------------------------------
// plane_quantized_dedup_set
// Deduplicating set of quantized plane keys.
// ----------------------------------------------------------------------------
// in:  plane normal (Q2.14) and point (Q16.16), valid/ready.
// out: one result per input: is_new, dropped and the four-part key.
// cfg: index 0 angle_step, index 1 length_step; write only while idle.
// One item at a time. Steps: load, a serial dot product (one multiply per
// component), four divisions through a shared restoring divider (one
// quotient bit per cycle), a table scan through the single RAM read port,
// one store, then the result is held.
// in_ready is high only while idle. A stalled receiver holds out_valid and
// the result until taken; no new item is accepted meanwhile.
// Reset empties the table (fill count zero) and restores both steps; the
// key store itself needs no clearing pass.
// ----------------------------------------------------------------------------
module plane_quantized_dedup_set #(
  parameter int TABLE_DEPTH = pqds_pkg::TABLE_DEPTH_DEF
) (
  input logic clk,
  input logic rst_n,
  pqds_in_if.sink    in_ch,
  pqds_out_if.source out_ch,
  pqds_cfg_if.sink   cfg_ch
);
  import pqds_pkg::*;
  `include "plane_quantized_dedup_set_assert.svh"

  logic [14:0] angle_r;
  logic [30:0] length_r;
  pqds_cmd_t   cmd;
  pqds_sts_t   sts;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      angle_r  <= ANGLE_RST;
      length_r <= LENGTH_RST;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        CFG_ANGLE:  angle_r  <= cfg_ch.data[14:0];
        CFG_LENGTH: length_r <= cfg_ch.data[30:0];
        default: ;
      endcase
    end
  end

  pqds_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .out_valid(out_ch.valid),
    .out_ready(out_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  pqds_dp #(.TABLE_DEPTH(TABLE_DEPTH)) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .angle_step (angle_r),
    .length_step(length_r),
    .in_nx      (in_ch.normal_x),
    .in_ny      (in_ch.normal_y),
    .in_nz      (in_ch.normal_z),
    .in_px      (in_ch.point_x),
    .in_py      (in_ch.point_y),
    .in_pz      (in_ch.point_z),
    .is_new     (out_ch.is_new),
    .dropped    (out_ch.dropped),
    .key_nx     (out_ch.key_nx),
    .key_ny     (out_ch.key_ny),
    .key_nz     (out_ch.key_nz),
    .key_offset (out_ch.key_offset)
  );

  `PQD_ASSERT_IMPL(a_flags_excl, clk, rst_n, out_ch.valid, !(out_ch.is_new && out_ch.dropped))
  `PQD_ASSERT_IMPL(a_no_overlap, clk, rst_n, out_ch.valid, !in_ch.ready)
  `PQD_ASSERT_NEXT(a_accept_busy, clk, rst_n, in_ch.valid && in_ch.ready, !in_ch.ready)
endmodule

// ===== sv/pqds_ram.sv =====
// ----------------------------------------------------------------------------
// pqds_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module pqds_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

// ===== sv/pqds_ctrl.sv =====
// ----------------------------------------------------------------------------
// pqds_ctrl
// Sequencer: load, dot product, four divisions, table scan, store, output.
// ----------------------------------------------------------------------------
module pqds_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  pqds_pkg::pqds_sts_t sts,
  output pqds_pkg::pqds_cmd_t cmd
);
  import pqds_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DOT   = 3'd1;
  localparam logic [2:0] S_DIV   = 3'd2;
  localparam logic [2:0] S_SCAN  = 3'd3;
  localparam logic [2:0] S_STORE = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic [1:0] sel_r, sel_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);

  always_comb begin
    state_nxt   = state_r;
    sel_nxt     = sel_r;
    cmd.op      = OP_NONE;
    cmd.div_sel = sel_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = OP_LOAD;
          state_nxt = S_DOT;
        end
      end
      S_DOT: begin
        cmd.op = OP_DOT;
        if (sts.dot_done) begin
          sel_nxt   = 2'd0;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        cmd.op = OP_DIV;
        if (sts.div_done) begin
          sel_nxt = sel_r + 2'd1;
          if (sel_r == 2'd3) begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        cmd.op = OP_SCAN;
        if (sts.scan_done) begin
          state_nxt = S_STORE;
        end
      end
      S_STORE: begin
        cmd.op    = OP_STORE;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      sel_r   <= 2'd0;
    end else begin
      state_r <= state_nxt;
      sel_r   <= sel_nxt;
    end
  end
endmodule

// ===== sv/pqds_dp.sv =====
// ----------------------------------------------------------------------------
// pqds_dp
// Datapath: canonical normal, serial dot product, restoring divider,
// key table with sequential scan.
// ----------------------------------------------------------------------------
module pqds_dp #(
  parameter int TABLE_DEPTH = pqds_pkg::TABLE_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  pqds_pkg::pqds_cmd_t  cmd,
  output pqds_pkg::pqds_sts_t  sts,
  input  logic [14:0]          angle_step,
  input  logic [30:0]          length_step,
  input  logic signed [15:0]   in_nx,
  input  logic signed [15:0]   in_ny,
  input  logic signed [15:0]   in_nz,
  input  logic signed [31:0]   in_px,
  input  logic signed [31:0]   in_py,
  input  logic signed [31:0]   in_pz,
  output logic                 is_new,
  output logic                 dropped,
  output logic signed [15:0]   key_nx,
  output logic signed [15:0]   key_ny,
  output logic signed [15:0]   key_nz,
  output logic signed [31:0]   key_offset
);
  import pqds_pkg::*;

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

  // Offset in Q21.30 fits 51 signed bits; dividends handled as magnitudes.
  localparam int DW = 51;

  logic signed [16:0] n_r [3];
  logic signed [31:0] p_r [3];
  logic signed [DW-1:0] d_r;
  logic [1:0]  dot_k_r;

  // divider
  logic          div_busy_r;
  logic [5:0]    div_cnt_r;
  logic [DW-1:0] quo_r;
  logic [DW-1:0] rem_r;
  logic [DW-1:0] dvd_r;
  logic [45:0]   dvs_r;
  logic          neg_r;

  logic signed [15:0] q_r [3];
  logic signed [31:0] ko_r;

  // table
  logic [CW-1:0] count_r;
  logic [CW-1:0] scan_r;
  logic          scan_rd_r;
  logic          found_r;
  logic          scan_end_r;
  logic [AW-1:0] ram_addr;
  logic          ram_we;
  logic [79:0]   ram_wdata, ram_rdata;

  logic signed [48:0] prod;
  logic [DW-1:0]  dvd_mag;
  logic [45:0]    dvs_val;
  logic [46:0]    trial;
  logic [DW-1:0]  rem_sh;
  logic signed [DW:0] qs;
  logic           flip;
  logic [79:0]    key_w;

  always_comb begin
    if (in_nx != 16'sd0) flip = in_nx[15];
    else if (in_ny != 16'sd0) flip = in_ny[15];
    else flip = in_nz[15];
  end

  assign prod = p_r[dot_k_r] * n_r[dot_k_r];

  always_comb begin
    logic signed [DW-1:0] sv;
    if (cmd.div_sel == 2'd3) begin
      sv      = d_r;
      dvs_val = {(length_step == 31'd0) ? 31'd1 : length_step, 14'd0, 1'b0} >> 1;
    end else begin
      sv      = DW'(n_r[cmd.div_sel]);
      dvs_val = 46'((angle_step == 15'd0) ? 15'd1 : angle_step);
    end
    dvd_mag = sv[DW-1] ? DW'(-sv) : DW'(sv);
  end

  assign rem_sh = {rem_r[DW-2:0], dvd_r[DW-1]};
  assign trial  = {1'b0, rem_sh[45:0]} - {1'b0, dvs_r};
  assign qs     = neg_r ? -$signed({1'b0, quo_r}) : $signed({1'b0, quo_r});

  assign key_w     = {q_r[0], q_r[1], q_r[2], ko_r};
  assign ram_addr  = (cmd.op == OP_STORE) ? count_r[AW-1:0] : scan_r[AW-1:0];
  assign ram_we    = (cmd.op == OP_STORE) && !found_r && (count_r < DEPTH_C);
  assign ram_wdata = key_w;

  pqds_ram #(.WIDTH(80), .DEPTH(TABLE_DEPTH)) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .addr (ram_addr),
    .wdata(ram_wdata),
    .rdata(ram_rdata)
  );

  assign sts.dot_done  = (cmd.op == OP_DOT) && (dot_k_r == 2'd2);
  assign sts.div_done  = (cmd.op == OP_DIV) && div_busy_r && (div_cnt_r == 6'd0);
  assign sts.scan_done = (cmd.op == OP_SCAN) && scan_end_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r    <= '0;
      div_busy_r <= 1'b0;
      scan_rd_r  <= 1'b0;
      scan_end_r <= 1'b0;
    end else begin
      case (cmd.op)
        OP_LOAD: begin
          n_r[0]  <= flip ? -17'(in_nx) : 17'(in_nx);
          n_r[1]  <= flip ? -17'(in_ny) : 17'(in_ny);
          n_r[2]  <= flip ? -17'(in_nz) : 17'(in_nz);
          p_r[0]  <= in_px;
          p_r[1]  <= in_py;
          p_r[2]  <= in_pz;
          d_r     <= '0;
          dot_k_r <= 2'd0;
        end
        OP_DOT: begin
          d_r     <= d_r + DW'(prod);
          dot_k_r <= dot_k_r + 2'd1;
        end
        OP_DIV: begin
          if (!div_busy_r) begin
            div_busy_r <= 1'b1;
            div_cnt_r  <= 6'(DW);
            dvd_r      <= dvd_mag;
            dvs_r      <= dvs_val;
            rem_r      <= '0;
            quo_r      <= '0;
            neg_r      <= (cmd.div_sel == 2'd3) ? d_r[DW-1] : n_r[cmd.div_sel][16];
          end else if (div_cnt_r != 6'd0) begin
            dvd_r     <= {dvd_r[DW-2:0], 1'b0};
            div_cnt_r <= div_cnt_r - 6'd1;
            if (!trial[46] && (rem_sh[DW-1:46] == '0)) begin
              rem_r <= DW'(trial[45:0]);
              quo_r <= {quo_r[DW-2:0], 1'b1};
            end else begin
              rem_r <= rem_sh;
              quo_r <= {quo_r[DW-2:0], 1'b0};
            end
          end else begin
            div_busy_r <= 1'b0;
            if (cmd.div_sel == 2'd3) begin
              if (qs > (DW+1)'(64'sh7FFFFFFF)) ko_r <= 32'sh7FFFFFFF;
              else if (qs < -(DW+1)'(64'sh80000000)) ko_r <= 32'sh80000000;
              else ko_r <= qs[31:0];
              scan_r     <= '0;
              scan_rd_r  <= 1'b0;
              found_r    <= 1'b0;
              scan_end_r <= (count_r == '0);
            end else begin
              if (qs > (DW+1)'(32767)) q_r[cmd.div_sel] <= 16'sh7FFF;
              else if (qs < -(DW+1)'(32768)) q_r[cmd.div_sel] <= 16'sh8000;
              else q_r[cmd.div_sel] <= qs[15:0];
            end
          end
        end
        OP_SCAN: begin
          // one entry issued per cycle, compared on the next; the read issued
          // at the fill count is past the last valid entry and is not compared
          scan_rd_r <= 1'b1;
          if (scan_rd_r && !scan_end_r && ram_rdata == key_w) begin
            found_r <= 1'b1;
          end
          if (!scan_end_r) begin
            if (scan_rd_r && (scan_r == count_r)) begin
              scan_end_r <= 1'b1;
            end else if (scan_r != count_r) begin
              scan_r <= scan_r + CW'(1);
            end
          end
        end
        OP_STORE: begin
          scan_end_r <= 1'b0;
          scan_rd_r  <= 1'b0;
          is_new     <= !found_r && (count_r < DEPTH_C);
          dropped    <= !found_r && (count_r >= DEPTH_C);
          if (ram_we) begin
            count_r <= count_r + CW'(1);
          end
          key_nx     <= q_r[0];
          key_ny     <= q_r[1];
          key_nz     <= q_r[2];
          key_offset <= ko_r;
        end
        default: ;
      endcase
    end
  end
endmodule

// ===== test/pqds_tb_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pqds_tb_if
// Holder for testbench-side helper types of the plane dedup set bench.
// ----------------------------------------------------------------------------
package pqds_tb_pkg;
  typedef struct packed {
    logic               is_new;
    logic               dropped;
    logic signed [15:0] key_nx;
    logic signed [15:0] key_ny;
    logic signed [15:0] key_nz;
    logic signed [31:0] key_offset;
  } plane_key_t;
endpackage

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Plane dedup set: directed table plus random planes against a key-set model.
// ----------------------------------------------------------------------------
module testbench;
  import pqds_pkg::*;
  import pqds_tb_pkg::*;

  logic clk;
  logic rst_n;
  pqds_in_if  in_ch ();
  pqds_out_if out_ch ();
  pqds_cfg_if cfg_ch ();

  plane_quantized_dedup_set dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  // model state
  logic [47:0]  seen_nkey[$];
  logic [31:0]  seen_okey[$];
  logic [14:0]  angle_q;
  logic [30:0]  length_q;
  plane_key_t   pending_keys[$];
  int           errors;
  int           got;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #200ms;
    $display("FAILED: results differ");
    $finish;
  end

  function automatic logic signed [63:0] div_trunc(logic signed [63:0] a, logic signed [63:0] b);
    logic [63:0] ua, ub, uq;
    ua = a[63] ? -a : a;
    ub = b[63] ? -b : b;
    uq = ua / ub;
    return (a[63] ^ b[63]) ? -$signed(uq) : $signed(uq);
  endfunction

  function automatic logic signed [63:0] clamp(logic signed [63:0] v, logic signed [63:0] lo,
                                               logic signed [63:0] hi);
    return (v < lo) ? lo : (v > hi) ? hi : v;
  endfunction

  function automatic plane_key_t quantize_plane(logic signed [15:0] nx, logic signed [15:0] ny,
      logic signed [15:0] nz, logic signed [31:0] px, logic signed [31:0] py,
      logic signed [31:0] pz);
    logic signed [63:0] n0, n1, n2, d, aq, lq;
    logic flip;
    logic [47:0] nk;
    logic [31:0] ok;
    bit found;
    plane_key_t r;
    n0 = nx; n1 = ny; n2 = nz;
    if (n0 != 0) flip = n0 < 0;
    else if (n1 != 0) flip = n1 < 0;
    else flip = n2 < 0;
    if (flip) begin
      n0 = -n0; n1 = -n1; n2 = -n2;
    end
    d = 64'(px) * n0 + 64'(py) * n1 + 64'(pz) * n2;
    aq = (angle_q == 0) ? 64'sd1 : 64'(angle_q);
    lq = (length_q == 0) ? 64'sd1 : 64'(length_q);
    r.key_nx = 16'(clamp(div_trunc(n0, aq), -32768, 32767));
    r.key_ny = 16'(clamp(div_trunc(n1, aq), -32768, 32767));
    r.key_nz = 16'(clamp(div_trunc(n2, aq), -32768, 32767));
    r.key_offset = 32'(clamp(div_trunc(d, lq * 16384), -64'sd2147483648, 64'sd2147483647));
    nk = {r.key_nz, r.key_ny, r.key_nx};
    ok = r.key_offset;
    found = 0;
    foreach (seen_nkey[i]) if (seen_nkey[i] == nk && seen_okey[i] == ok) found = 1;
    r.is_new = 0;
    r.dropped = 0;
    if (!found) begin
      if (seen_nkey.size() < TABLE_DEPTH_DEF) begin
        seen_nkey.push_back(nk);
        seen_okey.push_back(ok);
        r.is_new = 1;
      end else r.dropped = 1;
    end
    return r;
  endfunction

  task automatic idle_gap();
    int g;
    g = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) g = 0;
    repeat (g) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [31:0] val);
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    cfg_ch.valid <= 1'b1;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    if (idx == CFG_ANGLE) angle_q = val[14:0];
    else length_q = val[30:0];
    @(posedge clk);
  endtask

  // send one plane; typed: typed-in expectation used when given
  task automatic send_plane(logic signed [15:0] nx, logic signed [15:0] ny,
      logic signed [15:0] nz, logic signed [31:0] px, logic signed [31:0] py,
      logic signed [31:0] pz, bit typed, plane_key_t exp_key);
    plane_key_t p;
    idle_gap();
    in_ch.normal_x <= nx; in_ch.normal_y <= ny; in_ch.normal_z <= nz;
    in_ch.point_x <= px; in_ch.point_y <= py; in_ch.point_z <= pz;
    in_ch.valid <= 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    in_ch.valid <= 1'b0;
    p = quantize_plane(nx, ny, nz, px, py, pz);
    if (typed && p != exp_key) begin
      $display("%0t typed row disagrees with model: exp %p model %p", $time, exp_key, p);
      errors++;
    end
    pending_keys.push_back(typed ? exp_key : p);
    @(posedge clk);
  endtask

  task automatic drain();
    while (pending_keys.size() != 0) @(posedge clk);
    repeat (600) @(posedge clk);
  endtask

  // receiver with random stalls
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (pending_keys.size() == 0) begin
          $display("%0t unexpected transaction: got nx=%0d", $time, out_ch.key_nx);
          errors++;
        end else begin
          plane_key_t e;
          e = pending_keys.pop_front();
          if (e.is_new !== out_ch.is_new || e.dropped !== out_ch.dropped ||
              e.key_nx !== out_ch.key_nx || e.key_ny !== out_ch.key_ny ||
              e.key_nz !== out_ch.key_nz || e.key_offset !== out_ch.key_offset) begin
            $display("%0t mismatch: exp new=%b drop=%b %0d %0d %0d %0d", $time, e.is_new,
                     e.dropped, e.key_nx, e.key_ny, e.key_nz, e.key_offset);
            $display("%0t          got new=%b drop=%b %0d %0d %0d %0d", $time, out_ch.is_new,
                     out_ch.dropped, out_ch.key_nx, out_ch.key_ny, out_ch.key_nz,
                     out_ch.key_offset);
            errors++;
          end
          got++;
        end
      end
      if ($urandom_range(0, 19) == 0) out_ch.ready <= 1'b0;
      else if ($urandom_range(0, 1) == 0) out_ch.ready <= 1'b1;
    end
  end

  typedef struct {
    logic signed [15:0] nx, ny, nz;
    logic signed [31:0] px, py, pz;
    bit                 typed;
    plane_key_t         exp_key;
  } plane_row_t;

  plane_row_t dir_rows[10] = '{
    // zero plane at reset steps: new key all zero
    '{16'sd0, 16'sd0, 16'sd0, 32'sd0, 32'sd0, 32'sd0, 1, '{1, 0, 0, 0, 0, 0}},
    // same again: already present
    '{16'sd0, 16'sd0, 16'sd0, 32'sd0, 32'sd0, 32'sd0, 1, '{0, 0, 0, 0, 0, 0}},
    // unit x normal, point at x=1.0: offset 1
    '{16'sd16384, 16'sd0, 16'sd0, 32'sd65536, 32'sd0, 32'sd0, 1, '{1, 0, 10, 0, 0, 1}},
    // negative x normal flips to the same key
    '{-16'sd16384, 16'sd0, 16'sd0, 32'sd65536, 32'sd0, 32'sd0, 1, '{0, 0, 10, 0, 0, 1}},
    '{16'sd0, -16'sd16384, 16'sd5, 32'sd7, 32'sd70000, -32'sd9, 0, '{0, 0, 0, 0, 0, 0}},
    '{16'sd0, 16'sd0, -16'sd32768, 32'sd0, 32'sd0, 32'sd100000, 0, '{0, 0, 0, 0, 0, 0}},
    '{-16'sd32768, 16'sd32767, -16'sd32768, -32'sd2147483648, 32'sd2147483647,
      -32'sd2147483648, 0, '{0, 0, 0, 0, 0, 0}},
    '{16'sd32767, -16'sd32768, 16'sd32767, 32'sd2147483647, -32'sd2147483648,
      32'sd2147483647, 0, '{0, 0, 0, 0, 0, 0}},
    '{16'sd1, 16'sd1, 16'sd1, -32'sd1, -32'sd1, -32'sd1, 0, '{0, 0, 0, 0, 0, 0}},
    '{16'sd0, 16'sd0, 16'sd1, 32'sd0, 32'sd0, -32'sd65535, 0, '{0, 0, 0, 0, 0, 0}}
  };

  function automatic logic signed [15:0] rand_comp();
    case ($urandom_range(0, 5))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return 16'sd0;
      3: return 16'($urandom_range(0, 40)) - 16'sd20;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic signed [31:0] rand_point();
    case ($urandom_range(0, 5))
      0: return 32'sh80000000;
      1: return 32'sh7fffffff;
      2: return 32'($urandom_range(0, 2000000)) - 32'sd1000000;
      default: return 32'($urandom);
    endcase
  endfunction

  initial begin
    plane_key_t none;
    logic [31:0] steps_a[4];
    logic [31:0] steps_l[4];
    steps_a = '{32'd1, 32'd32767, 32'd0, 32'd4000};
    steps_l = '{32'd1, 32'h7fffffff, 32'd0, 32'd65536};
    none = '{0, 0, 0, 0, 0, 0};
    errors = 0;
    got = 0;
    angle_q = ANGLE_RST;
    length_q = LENGTH_RST;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.normal_x = '0; in_ch.normal_y = '0; in_ch.normal_z = '0;
    in_ch.point_x = '0; in_ch.point_y = '0; in_ch.point_z = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = CFG_ANGLE;
    cfg_ch.data = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i])
      send_plane(dir_rows[i].nx, dir_rows[i].ny, dir_rows[i].nz, dir_rows[i].px,
                 dir_rows[i].py, dir_rows[i].pz, dir_rows[i].typed, dir_rows[i].exp_key);
    drain();

    // four phases of settings; coarse steps make repeats, fine steps fill the table
    for (int ph = 0; ph < 4; ph++) begin
      write_reg(CFG_ANGLE, steps_a[ph] | ($urandom_range(0, 1) << 15));
      write_reg(CFG_LENGTH, steps_l[ph] | ($urandom_range(0, 1) << 31));
      for (int k = 0; k < 375; k++) begin
        if ($urandom_range(0, 2) == 0 && seen_nkey.size() > 0)
          // repeat a simple plane so lookups hit stored keys
          send_plane(16'sd16384, 16'sd0, 16'sd0, 32'($urandom_range(0, 3)) <<< 16, 0, 0,
                     0, none);
        else
          send_plane(rand_comp(), rand_comp(), rand_comp(), rand_point(), rand_point(),
                     rand_point(), 0, none);
      end
      drain();
    end

    if (errors == 0) $display("PASSED: all results match");
    else $display("FAILED: results differ");
    $finish;
  end
endmodule
